// File: rtl/core/whmc_pkg.sv
// Shared types and constants of the weighted Hamming match counter.
// Used by whmc_ctrl, whmc_dpath and weighted_hamming_match_count.
`timescale 1ns / 1ps
`default_nettype none

package whmc_pkg;

  localparam int PAT_W   = 12;
  localparam int DEPTH   = 1 << PAT_W;
  localparam int CNT_W   = 20;
  localparam int WGT_W   = 7;
  localparam int WREG_W  = 42;
  localparam int THR_W   = 7;
  localparam int HALF    = 6;
  localparam int HALF_W  = 10;
  localparam int SIM_W   = 11;

  typedef enum logic [0:0] {
    REG_WEIGHTS_LOW  = 1'b0,
    REG_WEIGHTS_HIGH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic addr_inc;
    logic wr_zero;
    logic rd_item;
    logic wr_inc;
    logic scan_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic addr_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/weighted_hamming_match_count.sv
// Top level of the weighted Hamming match counter: joins the sequencer
// and the datapath. Depends on whmc_pkg, whmc_ctrl and whmc_dpath.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+------------------
//  input   | in_kind, in_pattern, in_threshold          | start && !busy
//  result  | out_match_count                            | out_valid strobe
//  config  | cfg_index, cfg_wdata                       | cfg_we
//
// An insert word passes through accept, histogram read and write back.
// A query word passes through accept, a scan of the whole histogram reading one
// entry a cycle, a pipeline drain and a one-cycle result strobe.
// After reset a clearing pass zeroes the histogram with busy
// high; configuration writes are taken throughout.
// The receiver cannot stall; out_valid lasts exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module weighted_hamming_match_count #(
  parameter int BITS          = 12,
  parameter int MAX_THRESHOLD = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [whmc_pkg::WREG_W-1:0]   cfg_wdata,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [whmc_pkg::PAT_W-1:0]    in_pattern,
  input  wire logic [whmc_pkg::THR_W-1:0]    in_threshold,
  output logic                               out_valid,
  output logic [whmc_pkg::CNT_W-1:0]         out_match_count
);

  whmc_pkg::dp_cmd_t    cmd;
  whmc_pkg::dp_status_t status;

  whmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  whmc_dpath #(
    .BITS          (BITS),
    .MAX_THRESHOLD (MAX_THRESHOLD)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_pattern   (in_pattern),
    .in_threshold (in_threshold),
    .cmd          (cmd),
    .status       (status),
    .match_count  (out_match_count)
  );

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_early_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(start && !busy))
    else $error("result straight after accept");

  a_idle_after_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block not idle after result");

endmodule

`default_nettype wire

// File: rtl/core/whmc_ctrl.sv
// Sequencer of the weighted Hamming match counter: clearing pass, insert
// read-modify-write and query scan. Depends on whmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module whmc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 in_kind,
  input  wire whmc_pkg::dp_status_t status,
  output whmc_pkg::dp_cmd_t         cmd,
  output logic                      busy,
  output logic                      out_valid
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_INS_RD = 9'b000000100,
    S_INS_WR = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_DRAIN1 = 9'b000100000,
    S_DRAIN2 = 9'b001000000,
    S_DRAIN3 = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_zero  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (status.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = in_kind ? S_SCAN : S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_inc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (status.addr_last) begin
          state_nxt = S_DRAIN1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_DRAIN3;
      S_DRAIN3: state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire

// File: rtl/core/whmc_dpath.sv
// Datapath of the weighted Hamming match counter: weight registers,
// histogram memory, similarity pipeline and saturating accumulator.
// Depends on whmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module whmc_dpath #(
  parameter int BITS          = 12,
  parameter int MAX_THRESHOLD = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [whmc_pkg::WREG_W-1:0]   cfg_wdata,
  input  wire logic [whmc_pkg::PAT_W-1:0]    in_pattern,
  input  wire logic [whmc_pkg::THR_W-1:0]    in_threshold,
  input  wire whmc_pkg::dp_cmd_t             cmd,
  output whmc_pkg::dp_status_t               status,
  output logic [whmc_pkg::CNT_W-1:0]         match_count
);

  localparam logic [whmc_pkg::SIM_W-1:0] THR_CAP = whmc_pkg::SIM_W'(MAX_THRESHOLD);

  logic [whmc_pkg::WREG_W-1:0] wlo_r;
  logic [whmc_pkg::WREG_W-1:0] whi_r;
  logic [whmc_pkg::PAT_W-1:0]  pattern_r;
  logic [whmc_pkg::SIM_W-1:0]  thr_r;
  logic [whmc_pkg::SIM_W-1:0]  thr_ext;
  logic [whmc_pkg::PAT_W-1:0]  addr_r;
  logic [whmc_pkg::PAT_W-1:0]  rd_addr;
  logic [whmc_pkg::CNT_W-1:0]  mem [whmc_pkg::DEPTH];
  logic [whmc_pkg::CNT_W-1:0]  rd_data_r;
  logic [whmc_pkg::CNT_W-1:0]  inc_val;
  logic [whmc_pkg::PAT_W-1:0]  a1_r;
  logic                        v1_r;
  logic [whmc_pkg::HALF_W-1:0] slo_nxt;
  logic [whmc_pkg::HALF_W-1:0] shi_nxt;
  logic [whmc_pkg::HALF_W-1:0] slo2_r;
  logic [whmc_pkg::HALF_W-1:0] shi2_r;
  logic [whmc_pkg::CNT_W-1:0]  cnt2_r;
  logic                        v2_r;
  logic [whmc_pkg::SIM_W-1:0]  sim;
  logic                        hit3_r;
  logic [whmc_pkg::CNT_W-1:0]  cnt3_r;
  logic                        v3_r;
  logic [whmc_pkg::CNT_W:0]    acc_sum;
  logic [whmc_pkg::CNT_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlo_r <= '0;
      whi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        whmc_pkg::REG_WEIGHTS_LOW:  wlo_r <= cfg_wdata;
        whmc_pkg::REG_WEIGHTS_HIGH: whi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign thr_ext = whmc_pkg::SIM_W'(in_threshold);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pattern_r <= in_pattern;
      thr_r     <= (thr_ext > THR_CAP) ? THR_CAP : thr_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.addr_inc) begin
      addr_r <= addr_r + whmc_pkg::PAT_W'(1);
    end
  end

  assign status.addr_last = &addr_r;

  assign rd_addr = cmd.rd_item ? pattern_r : addr_r;
  assign inc_val = (&rd_data_r) ? rd_data_r : rd_data_r + whmc_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.wr_zero) begin
      mem[addr_r] <= '0;
    end else if (cmd.wr_inc) begin
      mem[pattern_r] <= inc_val;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    slo_nxt = '0;
    shi_nxt = '0;
    for (int j = 0; j < whmc_pkg::HALF; j++) begin
      if (j < BITS && pattern_r[j] == a1_r[j]) begin
        slo_nxt = slo_nxt + whmc_pkg::HALF_W'(wlo_r[j*whmc_pkg::WGT_W +: whmc_pkg::WGT_W]);
      end
      if (j + whmc_pkg::HALF < BITS &&
          pattern_r[j+whmc_pkg::HALF] == a1_r[j+whmc_pkg::HALF]) begin
        shi_nxt = shi_nxt + whmc_pkg::HALF_W'(whi_r[j*whmc_pkg::WGT_W +: whmc_pkg::WGT_W]);
      end
    end
  end

  assign sim = whmc_pkg::SIM_W'(slo2_r) + whmc_pkg::SIM_W'(shi2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= addr_r;
    slo2_r <= slo_nxt;
    shi2_r <= shi_nxt;
    cnt2_r <= rd_data_r;
    hit3_r <= (sim <= thr_r);
    cnt3_r <= cnt2_r;
  end

  assign acc_sum = {1'b0, acc_r} + {1'b0, cnt3_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (v3_r && hit3_r) begin
      acc_r <= acc_sum[whmc_pkg::CNT_W] ? '1 : acc_sum[whmc_pkg::CNT_W-1:0];
    end
  end

  assign match_count = acc_r;

endmodule

`default_nettype wire

// File: bench/weighted_hamming_match_count_tb.sv
// Self-checking bench for the weighted Hamming match counter: a histogram
// model predicts each query count and a board compares it with the strobed result.
// Depends on whmc_pkg and weighted_hamming_match_count.
`timescale 1ns / 1ps

module weighted_hamming_match_count_tb;

  localparam int PAT_W     = whmc_pkg::PAT_W;
  localparam int CNT_W     = whmc_pkg::CNT_W;
  localparam int WREG_W    = whmc_pkg::WREG_W;
  localparam int WGT_W     = whmc_pkg::WGT_W;
  localparam int THR_W     = whmc_pkg::THR_W;
  localparam int HALF      = whmc_pkg::HALF;
  localparam int BITS_N    = 12;
  localparam int MAX_THR   = 100;
  localparam int COUNT_MAX = (1 << CNT_W) - 1;
  localparam int LIMIT     = 3_000_000;

  typedef enum bit {
    WORD_INSERT = 1'b0,
    WORD_QUERY  = 1'b1
  } word_kind_t;

  class match_count_board;
    int unsigned     hist [bit [PAT_W-1:0]];
    bit [WREG_W-1:0] weights_lo;
    bit [WREG_W-1:0] weights_hi;
    bit [CNT_W-1:0]  pending_counts [$];
    int              fails;

    function void set_weights(whmc_pkg::cfg_reg_t idx, bit [WREG_W-1:0] value);
      if (idx == whmc_pkg::REG_WEIGHTS_LOW) begin
        weights_lo = value;
      end else begin
        weights_hi = value;
      end
    endfunction

    function int unsigned similarity(bit [PAT_W-1:0] a, bit [PAT_W-1:0] b);
      bit [PAT_W-1:0] agree;
      int unsigned    sum;
      agree = ~(a ^ b);
      sum = 0;
      for (int j = 0; j < BITS_N; j++) begin
        if (agree[j]) begin
          if (j < HALF) begin
            sum += weights_lo[WGT_W*j +: WGT_W];
          end else begin
            sum += weights_hi[WGT_W*(j-HALF) +: WGT_W];
          end
        end
      end
      return sum;
    endfunction

    function bit [CNT_W-1:0] count_matches(bit [PAT_W-1:0] pat, bit [THR_W-1:0] thr);
      int unsigned limit_thr;
      int unsigned total;
      limit_thr = (thr > MAX_THR) ? MAX_THR : thr;
      total = 0;
      foreach (hist[p]) begin
        if (similarity(pat, p) <= limit_thr) begin
          total += hist[p];
          if (total > COUNT_MAX) begin
            total = COUNT_MAX;
          end
        end
      end
      return total[CNT_W-1:0];
    endfunction

    function void note_word(word_kind_t kind, bit [PAT_W-1:0] pat, bit [THR_W-1:0] thr);
      if (kind == WORD_INSERT) begin
        if (!hist.exists(pat)) begin
          hist[pat] = 0;
        end
        if (hist[pat] < COUNT_MAX) begin
          hist[pat]++;
        end
      end else begin
        pending_counts = {pending_counts, count_matches(pat, thr)};
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_count(logic [CNT_W-1:0] got);
      bit [CNT_W-1:0] want;
      if (pending_counts.size() == 0) begin
        report($sformatf("match_count %0d with no query outstanding", got));
      end else begin
        want = pending_counts.pop_front();
        if (got !== want) begin
          report($sformatf("match_count expected %0d got %0d", want, got));
        end
      end
    endtask

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [WREG_W-1:0] cfg_wdata = '0;
  logic              start = 1'b0;
  logic              in_kind = 1'b0;
  logic [PAT_W-1:0]  in_pattern = '0;
  logic [THR_W-1:0]  in_threshold = '0;
  logic              busy;
  logic              out_valid;
  logic [CNT_W-1:0]  out_match_count;
  int                cycles = 0;

  match_count_board board = new();

  weighted_hamming_match_count #(
    .BITS          (BITS_N),
    .MAX_THRESHOLD (MAX_THR)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_pattern      (in_pattern),
    .in_threshold    (in_threshold),
    .out_valid       (out_valid),
    .out_match_count (out_match_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      board.check_count(out_match_count);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold start high until the word is taken.
  task send_word(word_kind_t kind, bit [PAT_W-1:0] pat, bit [THR_W-1:0] thr);
    start <= 1'b1;
    in_kind <= kind;
    in_pattern <= pat;
    in_threshold <= thr;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    board.note_word(kind, pat, thr);
  endtask

  task idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drain outstanding queries, then let a trailing insert finish.
  task settle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_weights(bit [WREG_W-1:0] lo, bit [WREG_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= whmc_pkg::REG_WEIGHTS_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= whmc_pkg::REG_WEIGHTS_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_weights(whmc_pkg::REG_WEIGHTS_LOW, lo);
    board.set_weights(whmc_pkg::REG_WEIGHTS_HIGH, hi);
  endtask

  function bit [WREG_W-1:0] random_weights(int maxw);
    bit [WREG_W-1:0] w;
    w = '0;
    for (int k = 0; k < HALF; k++) begin
      w[WGT_W*k +: WGT_W] = WGT_W'($urandom_range(0, maxw));
    end
    return w;
  endfunction

  function bit [PAT_W-1:0] near(bit [PAT_W-1:0] base);
    bit [PAT_W-1:0] v;
    v = base;
    repeat ($urandom_range(0, 2)) v[$urandom_range(0, PAT_W-1)] ^= 1'b1;
    return v;
  endfunction

  // Inserts cluster round a few bases; half of the queries aim near their
  // complements, where similarity is low and counts are non-trivial.
  task random_phase(int n, bit gaps, bit [WREG_W-1:0] lo, bit [WREG_W-1:0] hi);
    bit [PAT_W-1:0] bases [4];
    bit [PAT_W-1:0] pat;
    bit [THR_W-1:0] thr;
    int             pick;
    settle();
    write_weights(lo, hi);
    foreach (bases[b]) bases[b] = PAT_W'($urandom);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 3);
      thr = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, 127))
                                        : THR_W'($urandom_range(0, 40));
      if ($urandom_range(0, 99) < 55) begin
        pat = ($urandom_range(0, 9) < 7) ? near(bases[pick]) : PAT_W'($urandom);
        send_word(WORD_INSERT, pat, thr);
      end else begin
        case ($urandom_range(0, 3)) inside
          0, 1: begin
            pat = near(~bases[pick]);
          end
          2: begin
            pat = near(bases[pick]);
          end
          default: begin
            pat = PAT_W'($urandom);
          end
        endcase
        send_word(WORD_QUERY, pat, thr);
      end
      if (gaps && $urandom_range(0, 2) == 0) begin
        idle_for($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset weights: every similarity is zero.
    send_word(WORD_QUERY, 12'h000, 7'd0);
    send_word(WORD_INSERT, 12'h000, 7'd0);
    send_word(WORD_INSERT, 12'hFFF, 7'd127);
    send_word(WORD_INSERT, 12'hA5A, 7'd0);
    send_word(WORD_INSERT, 12'h000, 7'd0);
    send_word(WORD_QUERY, 12'h5A5, 7'd0);
    send_word(WORD_QUERY, 12'hFFF, 7'd127);

    settle();
    write_weights({6{7'd127}}, '0);
    send_word(WORD_QUERY, 12'hFC0, 7'd0);
    send_word(WORD_QUERY, 12'h03F, 7'd100);
    send_word(WORD_QUERY, 12'hFFF, 7'd101);
    send_word(WORD_QUERY, 12'h000, 7'd127);

    settle();
    write_weights({6{7'd100}}, {6{7'd100}});
    send_word(WORD_INSERT, 12'hFFE, 7'd0);
    send_word(WORD_QUERY, 12'h001, 7'd100);
    send_word(WORD_QUERY, 12'h001, 7'd99);
    send_word(WORD_QUERY, 12'hFFF, 7'd100);

    random_phase(32, 1'b1, random_weights(10), random_weights(10));
    random_phase(31, 1'b1, random_weights(127), random_weights(8));
    random_phase(31, 1'b1, random_weights(8), random_weights(127));
    random_phase(31, 1'b0, random_weights(25), random_weights(25));

    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
